// File: hdl/ubds_pkg.sv
// shared constants for the uart baud divisor select unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package ubds_pkg;
	localparam int DIVISOR_BITS = 16;
	// quarter clock width, i.e. quotient width of clock/(4*baud)
	localparam int NUM_W  = 30;
	localparam int BAUD_W = 24;
	localparam int ERR_W  = 28;
	localparam int PROD_W = 58;
	localparam logic [32:0] DIV_MAX = (33'd1 << DIVISOR_BITS) - 33'd1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SATURATED = 2'd1,
		ST_TOO_SLOW  = 2'd2
	} status_t;

	// quotient and remainder leaving the divider pipeline
	typedef struct packed {
		logic              valid;
		logic              zero_baud;
		logic [NUM_W-1:0]  quo;
		logic [BAUD_W-1:0] rem;
		logic [BAUD_W-1:0] baud;
		logic [1:0]        clk_lo;
	} div_res_t;
endpackage

// File: hdl/ubds_div.sv
// restoring divider pipeline: floor(clock_hz/4) / baud_rate, one bit per stage
// depends on ubds_pkg
`timescale 1ns / 1ps
module ubds_div import ubds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [31:0]       clock_hz,
	input  logic [BAUD_W-1:0] baud_rate,
	output div_res_t          res
);
	logic              valid_s [NUM_W+1];
	logic              zero_s  [NUM_W+1];
	logic [NUM_W-1:0]  num_s   [NUM_W+1];
	logic [NUM_W-1:0]  quo_s   [NUM_W+1];
	logic [BAUD_W-1:0] rem_s   [NUM_W+1];
	logic [BAUD_W-1:0] den_s   [NUM_W+1];
	logic [1:0]        lo_s    [NUM_W+1];

	// stage zero is the request itself
	assign valid_s[0] = in_valid;
	assign zero_s[0]  = (baud_rate == '0);
	assign num_s[0]   = clock_hz[31:2];
	assign quo_s[0]   = '0;
	assign rem_s[0]   = '0;
	assign den_s[0]   = baud_rate;
	assign lo_s[0]    = clock_hz[1:0];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [BAUD_W:0] trial;
		logic [BAUD_W:0] diff;
		logic            fits;
		// bring down one numerator bit and try the subtraction
		always_comb begin
			trial = {rem_s[i], num_s[i][NUM_W-1]};
			diff  = trial - {1'b0, den_s[i]};
			fits  = (trial >= {1'b0, den_s[i]});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			num_s[i+1]  <= {num_s[i][NUM_W-2:0], 1'b0};
			quo_s[i+1]  <= {quo_s[i][NUM_W-2:0], fits};
			rem_s[i+1]  <= fits ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
			den_s[i+1]  <= den_s[i];
			lo_s[i+1]   <= lo_s[i];
		end
	end

	assign res.valid     = valid_s[NUM_W];
	assign res.zero_baud = zero_s[NUM_W];
	assign res.quo       = quo_s[NUM_W];
	assign res.rem       = rem_s[NUM_W];
	assign res.baud      = den_s[NUM_W];
	assign res.clk_lo    = lo_s[NUM_W];
endmodule

// File: hdl/ubds_sel.sv
// error terms, cross multiplication and mode choice over three stages
// depends on ubds_pkg
`timescale 1ns / 1ps
module ubds_sel import ubds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_res_t    res,
	output logic        done,
	output logic [15:0] divisor,
	output logic        high_speed,
	output logic [1:0]  status
);
	logic               valid_s1, valid_s2;
	logic               zero_s1, zero_s2;
	logic [NUM_W-1:0]   q4_s1, q4_s2;
	logic [ERR_W-1:0]   e4_s1, e16_s1;
	logic [PROD_W-1:0]  lhs_s2, rhs_s2;
	logic [ERR_W-1:0]   e16_c;

	// x4 error is 4*rem plus the dropped clock bits; x16 adds baud*(q4 mod 4)*4
	always_comb begin
		e16_c = {2'b0, res.rem, res.clk_lo}
			+ ({4'b0, res.baud} * {26'b0, res.quo[1:0]} << 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= res.valid;
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

	// stage 1: error terms
	always_ff @(posedge clk) begin
		zero_s1 <= res.zero_baud;
		q4_s1   <= res.quo;
		e4_s1   <= {2'b0, res.rem, res.clk_lo};
		e16_s1  <= e16_c;
	end

	// stage 2: 4*e4*q16 against e16*q4
	always_ff @(posedge clk) begin
		zero_s2 <= zero_s1;
		q4_s2   <= q4_s1;
		lhs_s2  <= {30'b0, e4_s1[ERR_W-3:0], 2'b0} * {30'b0, q4_s1[NUM_W-1:2]};
		rhs_s2  <= {30'b0, e16_s1} * {28'b0, q4_s1};
	end

	// stage 3: choose mode and saturate, or report too slow for a zero baud or quotient
	logic             hs_c;
	logic [NUM_W-1:0] q_c, dm1_c;
	logic [32:0]      sat_c;
	logic             is_sat_c;
	always_comb begin
		hs_c     = (q4_s2[NUM_W-1:2] == '0) || (lhs_s2 < rhs_s2);
		q_c      = hs_c ? q4_s2 : {2'b0, q4_s2[NUM_W-1:2]};
		dm1_c    = q_c - {{(NUM_W-1){1'b0}}, 1'b1};
		is_sat_c = ({3'b0, dm1_c} > DIV_MAX);
		sat_c    = is_sat_c ? DIV_MAX : {3'b0, dm1_c};
	end

	always_ff @(posedge clk) begin
		if (zero_s2 || q4_s2 == '0) begin
			divisor    <= '0;
			high_speed <= 1'b0;
			status     <= ST_TOO_SLOW;
		end else begin
			divisor    <= sat_c[15:0];
			high_speed <= hs_c;
			status     <= is_sat_c ? ST_SATURATED : ST_OK;
		end
	end
endmodule

// File: hdl/uart_baud_divisor_select_unit.sv
// top level of the uart baud divisor select unit
// depends on ubds_pkg, ubds_div and ubds_sel
`timescale 1ns / 1ps
// A request (clock_hz, baud_rate) is taken whenever start is high; busy is
// always low, so a new request may enter every cycle. Each request gives one
// result on divisor, high_speed and status, marked by done for one cycle,
// once it has passed the bit-per-stage divider and then the stages for error
// terms, cross multiplication and selection. Results come out in request
// order and cannot be held off by the receiver.
module uart_baud_divisor_select_unit import ubds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] clock_hz,
	input  logic [23:0] baud_rate,
	output logic        done,
	output logic [15:0] divisor,
	output logic        high_speed,
	output logic [1:0]  status
);
	div_res_t div_res;

	// fully pipelined, never stalls
	assign busy = 1'b0;

	ubds_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.clock_hz  (clock_hz),
		.baud_rate (baud_rate),
		.res       (div_res)
	);

	ubds_sel u_sel (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (div_res),
		.done       (done),
		.divisor    (divisor),
		.high_speed (high_speed),
		.status     (status)
	);
endmodule

// File: sim/uart_baud_divisor_select_unit_test.sv
// self-checking testbench for the uart baud divisor select unit
// depends on ubds_pkg and the block's rtl; holds its own divisor predictor
`timescale 1ns / 1ps
module uart_baud_divisor_select_unit_test;
	import ubds_pkg::*;

	typedef struct {
		logic [15:0] divisor;
		logic        high_speed;
		status_t     status;
	} baud_choice_t;

	// work out the divisor and mode for one clock and baud pair
	function automatic baud_choice_t pick_divisor(logic [31:0] clk_hz, logic [23:0] baud);
		baud_choice_t r;
		logic [63:0] c, b, q4, q16, q, e4, e16, maxv;
		logic [127:0] lhs, rhs;
		c = clk_hz;
		b = baud;
		maxv = (64'd1 << DIVISOR_BITS) - 64'd1;
		q4 = 0;
		q16 = 0;
		if (b != 0) begin
			q4 = c / (4 * b);
			q16 = c / (16 * b);
		end
		r.divisor = '0;
		r.high_speed = 1'b0;
		r.status = ST_OK;
		if (q4 == 0) begin
			r.status = ST_TOO_SLOW;
			return r;
		end
		if (q16 == 0) begin
			q = q4;
			r.high_speed = 1'b1;
		end else begin
			e4 = (c >= 4 * q4 * b) ? c - 4 * q4 * b : 4 * q4 * b - c;
			e16 = (c >= 16 * q16 * b) ? c - 16 * q16 * b : 16 * q16 * b - c;
			lhs = e4 * (16 * q16);
			rhs = e16 * (4 * q4);
			if (lhs < rhs) begin
				q = q4;
				r.high_speed = 1'b1;
			end else begin
				q = q16;
			end
		end
		q = q - 1;
		if (q > maxv) begin
			q = maxv;
			r.status = ST_SATURATED;
		end
		r.divisor = q[15:0];
		return r;
	endfunction

	// queue of expected results, checked in request order
	class divisor_scoreboard;
		baud_choice_t pending[$];
		int errors;

		function void note_request(logic [31:0] clk_hz, logic [23:0] baud);
			pending.push_back(pick_divisor(clk_hz, baud));
		endfunction

		function void check_result(logic [15:0] d, logic hs, logic [1:0] st);
			baud_choice_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result divisor %0d", $time, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d !== e.divisor) begin
				$display("%0t: divisor expected %0d actual %0d", $time, e.divisor, d);
				errors++;
			end
			if (hs !== e.high_speed) begin
				$display("%0t: high_speed expected %0d actual %0d", $time, e.high_speed, hs);
				errors++;
			end
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_RANDOM = 1130;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [31:0] clock_hz = '0;
	logic [23:0] baud_rate = '0;
	logic done;
	logic [15:0] divisor;
	logic high_speed;
	logic [1:0] status;
	divisor_scoreboard board = new();
	int idle_cycles = 0;
	bit calm = 1'b0;

	uart_baud_divisor_select_unit dut (.*);

	always #10 clk = ~clk;

	// note requests and check results at each edge
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			board.note_request(clock_hz, baud_rate);
		if (arst_n && done)
			board.check_result(divisor, high_speed, status);
		if (arst_n && ((start && !busy) || done))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// stop the run when nothing moves for too long
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// present one request and hold it until taken
	task automatic send_request(logic [31:0] c, logic [23:0] b);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		clock_hz <= c;
		baud_rate <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// random pair, mostly in useful ranges
	task automatic send_random;
		logic [31:0] c;
		logic [23:0] b;
		case ($urandom_range(0, 5))
			0: begin
				c = $urandom;
				b = $urandom;
			end
			1: begin
				b = $urandom_range(1, 255);
				c = $urandom;
			end
			2: begin
				b = $urandom_range(1, 16777215);
				c = b * $urandom_range(1, 40);
			end
			3: begin
				b = $urandom_range(300, 921600);
				c = $urandom_range(1000000, 200000000);
			end
			4: begin
				b = $urandom_range(1, 16777215);
				c = $urandom_range(0, 64) * b * 4 + $urandom_range(0, 3);
			end
			default: begin
				b = $urandom_range(1, 64);
				c = $urandom_range(0, 32'hffffffff);
			end
		endcase
		send_request(c, b);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, zero baud, too slow, x4 only, tie, saturation
		send_request(32'hffffffff, 24'hffffff);
		send_request(32'hffffffff, 24'd1);
		send_request(32'd1, 24'd1);
		send_request(32'd0, 24'd0);
		send_request(32'hffffffff, 24'd0);
		send_request(32'd3, 24'd1);
		send_request(32'd4, 24'd1);
		send_request(32'd15, 24'd1);
		send_request(32'd16, 24'd1);
		send_request(32'd32, 24'd1);
		send_request(32'd48000000, 24'd115200);
		send_request(32'd1843200, 24'd9600);
		send_request(32'd100000000, 24'd3000000);
		send_request(32'd4194304, 24'd1);
		send_request(32'd4194303, 24'd1);
		send_request(32'd4194308, 24'd1);
		send_request(32'd1048580, 24'd1);
		send_request(32'h80000000, 24'h800000);
		send_request(32'h55555555, 24'haaaaaa);
		send_request(32'haaaaaaaa, 24'h555555);
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM - 150)
				calm = 1'b1;
			send_random();
		end
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
